/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Implication checked in the same cycle
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/mts_pkg.sv */
// ---------------------------------------------------------------------------
// mts_pkg
// Types, opcodes and the pitch-to-frequency table of the melody sequencer.
// ---------------------------------------------------------------------------
package mts_pkg;

    // Request opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_PLAY   = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_PAUSE  = 3'd4;
    localparam logic [2:0] OP_RESUME = 3'd5;

    // Configuration register indexes
    localparam logic CFG_NOTE_UNIT = 1'b0;
    localparam logic CFG_GAP       = 1'b1;

    // Pitch codes below this select a table frequency
    localparam logic [6:0] NUM_PITCH = 7'd97;

    // Input request, opcode in the lowest bits
    typedef struct packed {
        logic [7:0] note_length;
        logic [6:0] pitch_code;
        logic [5:0] address;
        logic [2:0] opcode;
    } mts_in_t;

    // Result, tone_on in the lowest bit
    typedef struct packed {
        logic        playing;
        logic [13:0] tone_freq;
        logic        tone_on;
    } mts_out_t;

    // Note store entry: length over pitch
    typedef struct packed {
        logic [7:0] note_length;
        logic [6:0] pitch_code;
    } mts_note_t;

    // Semitone frequencies in Hz from A1 (55 Hz) upward
    function automatic logic [13:0] pitch_freq(input logic [6:0] code);
        logic [13:0] f;
        unique case (code)
            7'd0:  f = 14'd55;    7'd1:  f = 14'd58;    7'd2:  f = 14'd62;
            7'd3:  f = 14'd65;    7'd4:  f = 14'd69;    7'd5:  f = 14'd73;
            7'd6:  f = 14'd78;    7'd7:  f = 14'd82;    7'd8:  f = 14'd87;
            7'd9:  f = 14'd92;    7'd10: f = 14'd98;    7'd11: f = 14'd104;
            7'd12: f = 14'd110;   7'd13: f = 14'd117;   7'd14: f = 14'd123;
            7'd15: f = 14'd131;   7'd16: f = 14'd139;   7'd17: f = 14'd147;
            7'd18: f = 14'd156;   7'd19: f = 14'd165;   7'd20: f = 14'd175;
            7'd21: f = 14'd185;   7'd22: f = 14'd196;   7'd23: f = 14'd208;
            7'd24: f = 14'd220;   7'd25: f = 14'd233;   7'd26: f = 14'd247;
            7'd27: f = 14'd262;   7'd28: f = 14'd277;   7'd29: f = 14'd294;
            7'd30: f = 14'd311;   7'd31: f = 14'd330;   7'd32: f = 14'd349;
            7'd33: f = 14'd370;   7'd34: f = 14'd392;   7'd35: f = 14'd415;
            7'd36: f = 14'd440;   7'd37: f = 14'd466;   7'd38: f = 14'd494;
            7'd39: f = 14'd523;   7'd40: f = 14'd554;   7'd41: f = 14'd587;
            7'd42: f = 14'd622;   7'd43: f = 14'd659;   7'd44: f = 14'd698;
            7'd45: f = 14'd740;   7'd46: f = 14'd784;   7'd47: f = 14'd831;
            7'd48: f = 14'd880;   7'd49: f = 14'd932;   7'd50: f = 14'd988;
            7'd51: f = 14'd1047;  7'd52: f = 14'd1109;  7'd53: f = 14'd1175;
            7'd54: f = 14'd1245;  7'd55: f = 14'd1319;  7'd56: f = 14'd1397;
            7'd57: f = 14'd1480;  7'd58: f = 14'd1568;  7'd59: f = 14'd1661;
            7'd60: f = 14'd1760;  7'd61: f = 14'd1865;  7'd62: f = 14'd1976;
            7'd63: f = 14'd2093;  7'd64: f = 14'd2217;  7'd65: f = 14'd2349;
            7'd66: f = 14'd2489;  7'd67: f = 14'd2637;  7'd68: f = 14'd2794;
            7'd69: f = 14'd2960;  7'd70: f = 14'd3136;  7'd71: f = 14'd3322;
            7'd72: f = 14'd3520;  7'd73: f = 14'd3729;  7'd74: f = 14'd3951;
            7'd75: f = 14'd4186;  7'd76: f = 14'd4435;  7'd77: f = 14'd4699;
            7'd78: f = 14'd4978;  7'd79: f = 14'd5274;  7'd80: f = 14'd5588;
            7'd81: f = 14'd5920;  7'd82: f = 14'd6272;  7'd83: f = 14'd6645;
            7'd84: f = 14'd7040;  7'd85: f = 14'd7459;  7'd86: f = 14'd7902;
            7'd87: f = 14'd8372;  7'd88: f = 14'd8870;  7'd89: f = 14'd9397;
            7'd90: f = 14'd9956;  7'd91: f = 14'd10548; 7'd92: f = 14'd11175;
            7'd93: f = 14'd11840; 7'd94: f = 14'd12544; 7'd95: f = 14'd13290;
            7'd96: f = 14'd14080;
            default: f = 14'd0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/melody_tone_sequencer.sv */
// A request's result is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle unless the result channel stalls; the note store
// prefetches the read pointer's entry every cycle, so a loading tick needs no extra read.
// Reset (aresetn low, synchronous): melody stopped, tone off, pointer zero,
// registers zero; the note store keeps its contents and no clearing pass runs.
// ---------------------------------------------------------------------------
// melody_tone_sequencer
// Note store, tick-driven countdown and tone register of a melody player.
// ---------------------------------------------------------------------------
module melody_tone_sequencer
    import mts_pkg::*;
#(
    parameter int NOTE_DEPTH = 64,
    parameter int REST_CODE  = 97,
    parameter int END_CODE   = 98
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[2:0] address[8:3] pitch_code[15:9] note_length[23:16]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // tone_on[0] tone_freq[14:1] playing[15]
    output logic        m_tlast,   // finished
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(NOTE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_DEPTH - 1);
    localparam logic [6:0] REST_C = 7'(REST_CODE);
    localparam logic [6:0] END_C  = 7'(END_CODE);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TONE = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    // Configuration registers
    logic [7:0] note_unit_reg;
    logic [7:0] gap_reg;

    // Sequencer state
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]       phase_reg, phase_next;
    logic [15:0]      cd_reg, cd_next;
    logic             running_reg, running_next;
    logic             held_reg, held_next;
    logic             tone_on_reg, tone_on_next;
    logic [13:0]      tone_freq_reg, tone_freq_next;
    logic             done;

    // Output register
    logic             m_tvalid_reg;
    mts_out_t         m_data_reg;
    logic             m_last_reg;

    // Note store and prefetch
    mts_note_t        note_mem [NOTE_DEPTH];
    mts_note_t        rd_data_reg;
    mts_note_t        byp_data_reg;
    logic             byp_reg;
    mts_note_t        entry;
    mts_note_t        wr_note;
    logic             store_we;
    logic [IDX_W-1:0] addr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] addr_wrap [64];

    mts_in_t          item;
    logic             accept;
    logic [15:0]      cd_dec;
    logic [15:0]      note_time;
    logic [15:0]      load_cd;

    assign item     = mts_in_t'(s_tdata);
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Wrap each request address into the store, one constant entry per address
    for (genvar g = 0; g < 64; g++) begin : g_addr_wrap
        assign addr_wrap[g] = IDX_W'(g % NOTE_DEPTH);
    end

    assign addr_idx = addr_wrap[item.address];
    assign wr_note  = '{note_length: item.note_length, pitch_code: item.pitch_code};
    assign store_we = accept && (item.opcode == OP_WRITE);

    // Read at the pointer the next request will see
    assign rd_idx = aresetn ? rd_ptr_next : '0;

    // Take the write data when it lands on the prefetched entry
    assign entry = byp_reg ? byp_data_reg : rd_data_reg;

    // Note time less the gap, floored at zero
    assign note_time = 16'(note_unit_reg) * 16'(entry.note_length);
    assign load_cd   = (note_time > 16'(gap_reg)) ? note_time - 16'(gap_reg) : 16'd0;
    assign cd_dec    = cd_reg - 16'(cd_reg != 16'd0);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_unit_reg <= '0;
            gap_reg       <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NOTE_UNIT: note_unit_reg <= cfg_wdata;
                CFG_GAP:       gap_reg       <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Note store with registered read and write-through bypass
    always_ff @(posedge aclk) begin
        if (store_we) begin
            note_mem[addr_idx] <= wr_note;
        end
        rd_data_reg  <= note_mem[rd_idx];
        byp_reg      <= store_we && (addr_idx == rd_idx);
        byp_data_reg <= wr_note;
    end

    // Step the sequencer on each accepted request
    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        phase_next     = phase_reg;
        cd_next        = cd_reg;
        running_next   = running_reg;
        held_next      = held_reg;
        tone_on_next   = tone_on_reg;
        tone_freq_next = tone_freq_reg;
        done           = 1'b0;
        if (accept) begin
            unique case (item.opcode)
                OP_TICK: begin
                    if (running_reg && !held_reg) begin
                        cd_next = cd_dec;
                        if (cd_dec == 16'd0) begin
                            priority if (phase_reg == PH_TONE) begin
                                // end of tone: start the gap
                                tone_on_next   = 1'b0;
                                tone_freq_next = '0;
                                phase_next     = PH_GAP;
                                cd_next        = 16'(gap_reg);
                            end else if (entry.pitch_code >= END_C) begin
                                // end code: stop the melody
                                tone_on_next   = 1'b0;
                                tone_freq_next = '0;
                                running_next   = 1'b0;
                                held_next      = 1'b0;
                                phase_next     = PH_IDLE;
                                cd_next        = '0;
                                done           = 1'b1;
                            end else begin
                                // load the next note or rest
                                if (entry.pitch_code != REST_C &&
                                    entry.pitch_code < NUM_PITCH) begin
                                    tone_on_next   = 1'b1;
                                    tone_freq_next = pitch_freq(entry.pitch_code);
                                end else begin
                                    tone_on_next   = 1'b0;
                                    tone_freq_next = '0;
                                end
                                cd_next     = load_cd;
                                rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0
                                            : rd_ptr_reg + 1'b1;
                                phase_next  = PH_TONE;
                            end
                        end
                    end
                end
                OP_PLAY: begin
                    tone_on_next   = 1'b0;
                    tone_freq_next = '0;
                    held_next      = 1'b0;
                    phase_next     = PH_IDLE;
                    cd_next        = '0;
                    rd_ptr_next    = addr_idx;
                    running_next   = 1'b1;
                end
                OP_STOP: begin
                    tone_on_next   = 1'b0;
                    tone_freq_next = '0;
                    running_next   = 1'b0;
                    held_next      = 1'b0;
                    phase_next     = PH_IDLE;
                    cd_next        = '0;
                end
                OP_PAUSE: begin
                    if (running_reg) begin
                        held_next      = 1'b1;
                        tone_on_next   = 1'b0;
                        tone_freq_next = '0;
                    end
                end
                OP_RESUME: begin
                    if (running_reg && held_reg) begin
                        held_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            phase_reg     <= PH_IDLE;
            cd_reg        <= '0;
            running_reg   <= 1'b0;
            held_reg      <= 1'b0;
            tone_on_reg   <= 1'b0;
            tone_freq_reg <= '0;
        end else begin
            rd_ptr_reg    <= rd_ptr_next;
            phase_reg     <= phase_next;
            cd_reg        <= cd_next;
            running_reg   <= running_next;
            held_reg      <= held_next;
            tone_on_reg   <= tone_on_next;
            tone_freq_reg <= tone_freq_next;
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= '{playing: running_next, tone_freq: tone_freq_next,
                            tone_on: tone_on_next};
            m_last_reg <= done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `ASSERT_IMPLY(a_tone_needs_run, aclk, aresetn, tone_on_reg, running_reg && !held_reg, "tone sounds outside a running melody")
    `ASSERT_IMPLY(a_held_needs_run, aclk, aresetn, held_reg, running_reg, "pause held without a melody")
    `ASSERT_IMPLY(a_silent_freq, aclk, aresetn, !tone_on_reg, tone_freq_reg == 14'd0, "frequency left over while silent")
    `ASSERT_IMPLY(a_idle_phase, aclk, aresetn, !running_reg, phase_reg == PH_IDLE && cd_reg == 16'd0, "countdown active while stopped")
    `ASSERT_ALWAYS(a_finish_stops, aclk, aresetn, !(m_tvalid_reg && m_last_reg) || !m_data_reg.playing, "finish reported while still playing")

endmodule

/* bench/tb_melody_tone_sequencer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_melody_tone_sequencer
// Self-checking bench for the melody sequencer. A queue of requests (note
// writes, plays, ticks, pause, resume, stop and spare opcodes) feeds a
// driver. A posedge monitor runs its own player model on every accepted
// request and checks each result, field by field, against that model.
// Note and gap timings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_melody_tone_sequencer;
    import mts_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int REST_PITCH  = 97;
    localparam int END_PITCH   = 98;
    localparam int RAND_ITEMS  = 1900;
    localparam int MAX_REPORTS = 10;

    // Opcodes the block must ignore
    localparam logic [2:0] OP_SPARE  = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TONE,
        SEQ_GAP
    } seq_phase_t;

    typedef struct packed {
        mts_out_t tone;
        logic     done;
    } tone_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_NOTE_UNIT;
    logic [7:0]  cfg_wdata = '0;

    // Request stream and the results it should produce
    mts_in_t      request_q[$];
    tone_result_t expected_tone_q[$];
    logic         req_taken = 1'b0;

    // Player model state
    mts_note_t   score[STORE_DEPTH];
    logic [5:0]  play_ptr    = '0;
    seq_phase_t  seq_phase   = SEQ_IDLE;
    logic [15:0] note_timer  = '0;
    logic        melody_on   = 1'b0;
    logic        melody_held = 1'b0;
    logic        tone_r      = 1'b0;
    logic [13:0] freq_r      = '0;
    logic [7:0]  unit_ms_r   = '0;
    logic [7:0]  gap_ms_r    = '0;

    // Timing the stimulus plans with
    int unit_plan = 0;
    int gap_plan  = 0;

    int error_count = 0;
    int req_count   = 0;
    int checked     = 0;
    int end_pulses  = 0;
    int melodies    = 0;
    int settings    = 0;
    int rand_items  = 0;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    melody_tone_sequencer #(
        .NOTE_DEPTH(STORE_DEPTH),
        .REST_CODE (REST_PITCH),
        .END_CODE  (END_PITCH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Equal-tempered semitone above A1 = 55 Hz, rounded to the nearest hertz
    function automatic logic [13:0] semitone_hz(input logic [6:0] code);
        real hz;
        int  whole;
        hz = 55.0 * (2.0 ** (code / 12.0));
        whole = $rtoi(hz + 0.5);
        return whole[13:0];
    endfunction

    function automatic void halt_player();
        tone_r      = 1'b0;
        freq_r      = '0;
        melody_on   = 1'b0;
        melody_held = 1'b0;
        seq_phase   = SEQ_IDLE;
        note_timer  = '0;
    endfunction

    // Apply one request to the model and return the result it shows
    task automatic step_player(input mts_in_t req, output tone_result_t res);
        mts_note_t entry;
        int        span;
        res.done = 1'b0;
        case (req.opcode)
            OP_TICK: begin
                if (melody_on && !melody_held) begin
                    if (note_timer != 0)
                        note_timer = note_timer - 1'b1;
                    if (note_timer == 0) begin
                        if (seq_phase == SEQ_TONE) begin
                            // note time over: silent gap follows
                            tone_r     = 1'b0;
                            freq_r     = '0;
                            seq_phase  = SEQ_GAP;
                            note_timer = 16'(gap_ms_r);
                        end else begin
                            entry = score[play_ptr];
                            if (entry.pitch_code >= END_PITCH) begin
                                halt_player();
                                res.done = 1'b1;
                            end else begin
                                tone_r = (entry.pitch_code < NUM_PITCH);
                                freq_r = tone_r ? semitone_hz(entry.pitch_code) : '0;
                                span = int'(unit_ms_r) * int'(entry.note_length);
                                note_timer = 16'((span > int'(gap_ms_r))
                                                 ? span - int'(gap_ms_r) : 0);
                                play_ptr  = play_ptr + 1'b1;
                                seq_phase = SEQ_TONE;
                            end
                        end
                    end
                end
            end
            OP_WRITE: begin
                score[req.address].pitch_code  = req.pitch_code;
                score[req.address].note_length = req.note_length;
            end
            OP_PLAY: begin
                halt_player();
                play_ptr  = req.address;
                melody_on = 1'b1;
            end
            OP_STOP: halt_player();
            OP_PAUSE: begin
                if (melody_on) begin
                    melody_held = 1'b1;
                    tone_r      = 1'b0;
                    freq_r      = '0;
                end
            end
            OP_RESUME: begin
                if (melody_on && melody_held)
                    melody_held = 1'b0;
            end
            default: ;
        endcase
        res.tone.tone_on   = tone_r;
        res.tone.tone_freq = tone_r ? freq_r : '0;
        res.tone.playing   = melody_on;
    endtask

    // Sample both channels and the config port at the rising edge
    always @(posedge aclk) begin : watch_bus
        tone_result_t predicted;
        tone_result_t wanted;
        mts_out_t     got;
        if (aresetn) begin
            if (cfg_we) begin
                if (cfg_index == CFG_NOTE_UNIT)
                    unit_ms_r = cfg_wdata;
                else
                    gap_ms_r = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                step_player(mts_in_t'(s_tdata), predicted);
                expected_tone_q.push_back(predicted);
                req_count++;
            end
            if (m_tvalid && m_tready) begin
                got = mts_out_t'(m_tdata);
                if (m_tlast === 1'b1)
                    end_pulses++;
                if (expected_tone_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result %h/%b with no request pending",
                                 m_tdata, m_tlast);
                end else begin
                    wanted = expected_tone_q.pop_front();
                    checked++;
                    if (got.tone_on !== wanted.tone.tone_on
                            || got.tone_freq !== wanted.tone.tone_freq
                            || got.playing !== wanted.tone.playing
                            || m_tlast !== wanted.done) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"result %0d mismatch (expected/actual): tone_on %b/%b",
                                      " freq %0d/%0d playing %b/%b finished %b/%b"},
                                     checked, wanted.tone.tone_on, got.tone_on,
                                     wanted.tone.tone_freq, got.tone_freq,
                                     wanted.tone.playing, got.playing, wanted.done, m_tlast);
                    end
                end
            end
        end
        req_taken <= s_tvalid && s_tready;
    end

    // Drive requests and result backpressure at the falling edge
    always @(negedge aclk) begin : drive_req
        int mode;
        cycle_count++;
        // rotate: no idling, sender idle, receiver stalling, both
        mode = (cycle_count / 300) % 4;
        idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 9 : 0;
        stall_pct = (mode == 2) ? 47 : (mode == 3) ? 9 : 0;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn) begin
            if (s_tvalid && !req_taken) begin
                // hold the request until it is taken
            end else if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= request_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic queue_req(input logic [2:0] op, input int addr,
                             input int pitch, input int len);
        mts_in_t req;
        req.opcode      = op;
        req.address     = addr[5:0];
        req.pitch_code  = pitch[6:0];
        req.note_length = len[7:0];
        request_q.push_back(req);
        rand_items++;
    endtask

    task automatic queue_tick();
        queue_req(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 127),
                  $urandom_range(0, 255));
    endtask

    // Wait until every request has been sent and answered, then settle
    task automatic wait_drained();
        do begin
            @(negedge aclk);
            // look after the driver's updates of this edge have landed
            #1;
        end while (request_q.size() != 0 || s_tvalid || expected_tone_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // Write both timing registers while the block is idle
    task automatic set_timing(input int unit_ms, input int gap);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOTE_UNIT;
        cfg_wdata <= unit_ms[7:0];
        @(negedge aclk);
        cfg_index <= CFG_GAP;
        cfg_wdata <= gap[7:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        unit_plan = unit_ms;
        gap_plan  = gap;
        settings++;
    endtask

    // Write a short melody with an end marker, play it and tick it through
    task automatic queue_melody(input int notes, input int len_max);
        int base;
        int span;
        int budget;
        int len;
        int pick;
        int pitch;
        base   = $urandom_range(0, STORE_DEPTH - 1);
        budget = 1;
        for (int i = 0; i < notes; i++) begin
            len   = $urandom_range(0, len_max);
            pitch = ($urandom_range(0, 6) == 0) ? REST_PITCH : $urandom_range(0, 96);
            queue_req(OP_WRITE, base + i, pitch, len);
            span = unit_plan * len;
            budget += ((span > gap_plan) ? span - gap_plan : 0) + gap_plan + 2;
        end
        queue_req(OP_WRITE, base + notes, $urandom_range(END_PITCH, 127),
                  $urandom_range(0, 255));
        queue_req(OP_PLAY, base, $urandom_range(0, 127), $urandom_range(0, 255));
        // cut some melodies short so the next play lands mid-note
        if ($urandom_range(0, 7) == 0)
            budget = $urandom_range(1, budget);
        for (int k = 0; k < budget; k++) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
                queue_req(OP_PAUSE, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255));
                repeat ($urandom_range(1, 3)) queue_tick();
                queue_req(OP_RESUME, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            end else if (pick == 1) begin
                queue_req(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, len_max));
            end else if (pick == 2) begin
                queue_req($urandom_range(0, 1) ? OP_SPARE : OP_UNUSED,
                          $urandom_range(0, 63), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            end else if (pick == 3) begin
                queue_req(OP_RESUME, $urandom_range(0, 63), 0, 0);
            end
            queue_tick();
        end
        if ($urandom_range(0, 5) == 0) begin
            queue_req(OP_STOP, $urandom_range(0, 63), $urandom_range(0, 127),
                      $urandom_range(0, 255));
            queue_req(OP_PAUSE, 0, 0, 0);
        end
        melodies++;
    endtask

    initial begin : timeout_guard
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        int tunes;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Fill the whole store so no play ever reads an unwritten entry
        for (int a = 0; a < STORE_DEPTH; a++)
            queue_req(OP_WRITE, a, $urandom_range(0, 127), $urandom_range(0, 255));

        // Idle requests: tick, pause and an unknown opcode do nothing
        queue_req(OP_TICK, 6'h2A, 7'h55, 8'hAA);
        queue_req(OP_PAUSE, 6'h15, 7'h2A, 8'h55);
        queue_req(OP_UNUSED, 6'h3F, 7'h7F, 8'hFF);
        // Lowest pitch at the last entry, wrapping to the top pitch, a rest, the end
        queue_req(OP_WRITE, 63, 0, 255);
        queue_req(OP_WRITE, 0, 96, 0);
        queue_req(OP_WRITE, 1, REST_PITCH, 1);
        queue_req(OP_WRITE, 2, 127, 0);
        queue_req(OP_PLAY, 63, 0, 0);
        // zero timing: every note and gap lasts one tick
        repeat (7) queue_tick();

        set_timing(2, 1);
        queue_req(OP_WRITE, 3, 36, 4);
        queue_req(OP_WRITE, 4, END_PITCH, 0);
        queue_req(OP_PLAY, 3, 0, 0);
        queue_tick();
        queue_tick();
        // pause freezes the count; resume keeps the tone silent
        queue_req(OP_PAUSE, 0, 0, 0);
        queue_tick();
        queue_req(OP_RESUME, 0, 0, 0);
        queue_tick();
        queue_req(OP_RESUME, 0, 0, 0);
        // play while running restarts, then stop without an end pulse
        queue_req(OP_PLAY, 63, 0, 0);
        queue_tick();
        queue_req(OP_STOP, 0, 0, 0);
        queue_req(OP_PAUSE, 0, 0, 0);

        // Random phases, each under its own timing
        phase_no = 0;
        while (rand_items < RAND_ITEMS) begin
            case (phase_no)
                0: set_timing(1, 0);
                1: set_timing(0, 2);
                2: set_timing(255, 255);
                3: set_timing(3, 7);
                default: set_timing($urandom_range(0, 3), $urandom_range(0, 4));
            endcase
            if (phase_no == 2) begin
                queue_melody(1, 1);
                // longest note time: count a few ticks into it, then stop
                queue_req(OP_WRITE, 10, 60, 255);
                queue_req(OP_WRITE, 11, END_PITCH, 0);
                queue_req(OP_PLAY, 10, 0, 0);
                repeat (5) queue_tick();
                queue_req(OP_PAUSE, 0, 0, 0);
                queue_tick();
                queue_req(OP_RESUME, 0, 0, 0);
                queue_tick();
                queue_req(OP_STOP, 0, 0, 0);
            end else begin
                tunes = $urandom_range(3, 8);
                for (int m = 0; m < tunes; m++) begin
                    // hold off the sender until every result is in
                    if (phase_no % 3 == 1 && m == tunes / 2)
                        wait_drained();
                    queue_melody($urandom_range(1, 5), $urandom_range(0, 6));
                end
            end
            phase_no++;
        end

        wait_drained();
        repeat (8) @(negedge aclk);
        $display("Ran %0d requests, %0d results checked, %0d melodies, %0d end pulses",
                 req_count, checked, melodies, end_pulses);
        $display("under %0d timing settings, with idle and stall mixes rotating.",
                 settings + 1);
        if (error_count == 0 && expected_tone_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
